// ===== hdl/txcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// Used by the cursor logic, the output buffer and the top level; no dependencies.
package txcw_pkg;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned BASE_W = 12;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic              cell_write;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
    logic              clear_screen;
    logic [IDX_W-1:0]  cursor_index;
  } result_t;

endpackage

// ===== hdl/txcw_cursor.sv =====
// Cursor state and per-character decode for the text console writer.
// Depends on txcw_pkg; produces one result_t per accepted character.
module txcw_cursor #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [txcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [txcw_pkg::ATTR_W-1:0]  attribute_i,
  output txcw_pkg::result_t            result_o
);

  localparam int unsigned PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int unsigned CW   = txcw_pkg::COL_W + 1;

  logic [txcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [txcw_pkg::ROW_W-1:0]  row_q, row_d;
  logic [txcw_pkg::BASE_W-1:0] base_q, base_d;
  logic [PH_W-1:0]             phase_q, phase_d;

  logic [CW-1:0]               col_inc;
  logic [CW-1:0]               tab_col;
  logic                        next_row;
  logic                        clear;
  logic                        wr;
  logic [txcw_pkg::BASE_W-1:0] cell_sum;
  logic [txcw_pkg::BASE_W-1:0] cursor_sum;

  // The tab phase tracks the column modulo the tab stop, so no divider is needed.
  always_comb begin
    col_inc  = {1'b0, col_q} + CW'(1);
    tab_col  = {1'b0, col_q} + CW'(TAB_STOP) - CW'(phase_q);
    col_d    = col_q;
    row_d    = row_q;
    base_d   = base_q;
    phase_d  = phase_q;
    next_row = 1'b0;
    clear    = 1'b0;
    wr       = 1'b0;
    case (char_code_i)
      txcw_pkg::CODE_NEWLINE: begin
        next_row = 1'b1;
      end
      txcw_pkg::CODE_TAB: begin
        if (tab_col >= CW'(COLUMNS)) begin
          next_row = 1'b1;
        end else begin
          col_d   = tab_col[txcw_pkg::COL_W-1:0];
          phase_d = '0;
        end
      end
      txcw_pkg::CODE_RETURN: begin
        col_d   = '0;
        phase_d = '0;
      end
      default: begin
        wr = 1'b1;
        if (col_inc >= CW'(COLUMNS)) begin
          next_row = 1'b1;
        end else begin
          col_d = col_inc[txcw_pkg::COL_W-1:0];
          if (phase_q == PH_W'(TAB_STOP - 1)) begin
            phase_d = '0;
          end else begin
            phase_d = phase_q + PH_W'(1);
          end
        end
      end
    endcase
    if (next_row) begin
      col_d   = '0;
      phase_d = '0;
      if (row_q == txcw_pkg::ROW_W'(ROWS - 1)) begin
        row_d  = '0;
        base_d = '0;
        clear  = 1'b1;
      end else begin
        row_d  = row_q + txcw_pkg::ROW_W'(1);
        base_d = base_q + txcw_pkg::BASE_W'(COLUMNS);
      end
    end
  end

  assign cell_sum   = base_q + txcw_pkg::BASE_W'(col_q);
  assign cursor_sum = base_d + txcw_pkg::BASE_W'(col_d);

  always_comb begin
    result_o.cell_write     = wr;
    result_o.cell_index     = wr ? cell_sum[txcw_pkg::IDX_W-1:0] : '0;
    result_o.cell_char      = wr ? char_code_i : '0;
    result_o.cell_attribute = wr ? attribute_i : '0;
    result_o.clear_screen   = clear;
    result_o.cursor_index   = cursor_sum[txcw_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      base_q  <= '0;
      phase_q <= '0;
    end else if (accept_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      base_q  <= base_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hdl/txcw_out_buf.sv =====
// Two-entry output buffer: a result register plus a skid register.
// Depends on txcw_pkg for the result_t payload type.
module txcw_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  txcw_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output txcw_pkg::result_t data_o
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  txcw_pkg::result_t main_q, main_d;
  txcw_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop = main_valid_q && !stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = data_i;
        main_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

endmodule

// ===== hdl/text_console_char_writer_top.sv =====
// Top level of the text console character writer: attribute register,
// cursor logic (txcw_cursor) and output buffer (txcw_out_buf); uses txcw_pkg.
//
//   Channel   Direction  Handshake                       Payload
//   input     in         in_valid_i / in_stall_o         char_code_i
//   result    out        out_valid_o / out_stall_i       cell_*_o, clear_screen_o, cursor_index_o
//   config    in         cfg_attribute_we_i              cfg_attribute_i
//
// One character is accepted per cycle unless the input stalls; its result is registered in the output buffer.
// The cursor update is a single pass over the column, row, row base and tab phase registers.
// Reset homes the cursor and sets the attribute to 0x07.
// A stalled result is held while one more character is taken into the skid register;
// the input stalls only when both output entries are full.
module text_console_char_writer_top #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [txcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic                         cfg_attribute_we_i,
  input  logic [txcw_pkg::ATTR_W-1:0]  cfg_attribute_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         cell_write_o,
  output logic [txcw_pkg::IDX_W-1:0]   cell_index_o,
  output logic [txcw_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [txcw_pkg::ATTR_W-1:0]  cell_attribute_o,
  output logic                         clear_screen_o,
  output logic [txcw_pkg::IDX_W-1:0]   cursor_index_o
);

  logic [txcw_pkg::ATTR_W-1:0] attr_q;
  logic                        accept;
  logic                        buf_full;
  txcw_pkg::result_t           result;
  txcw_pkg::result_t           out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= txcw_pkg::ATTR_RESET;
    end else if (cfg_attribute_we_i) begin
      attr_q <= cfg_attribute_i;
    end
  end

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  txcw_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .attribute_i (attr_q),
    .result_o    (result)
  );

  txcw_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign cell_write_o     = out_data.cell_write;
  assign cell_index_o     = out_data.cell_index;
  assign cell_char_o      = out_data.cell_char;
  assign cell_attribute_o = out_data.cell_attribute;
  assign clear_screen_o   = out_data.clear_screen;
  assign cursor_index_o   = out_data.cursor_index;

endmodule

// ===== hdl/txcw_checker.sv =====
// Port-level checks for the text console character writer, bound to the top level.
// Depends on txcw_pkg for field widths.
module txcw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         cell_write_o,
  input logic [txcw_pkg::IDX_W-1:0]   cell_index_o,
  input logic [txcw_pkg::CHAR_W-1:0]  cell_char_o,
  input logic [txcw_pkg::ATTR_W-1:0]  cell_attribute_o,
  input logic                         clear_screen_o,
  input logic [txcw_pkg::IDX_W-1:0]   cursor_index_o
);

  // A clear always homes the cursor.
  a_clear_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_screen_o |-> cursor_index_o == '0)
    else $error("clear_screen without cursor at home");

  // Control codes carry an all-zero cell write.
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cell_write_o |->
      cell_index_o == '0 && cell_char_o == '0 && cell_attribute_o == '0)
    else $error("cell fields not zero for a control code");

  // The input stalls only once a result was already waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o) && $past(out_stall_i))
    else $error("input stalled with no waiting result");

  // After an accepted character, a result is always valid in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

bind text_console_char_writer_top txcw_checker u_txcw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .cell_write_o     (cell_write_o),
  .cell_index_o     (cell_index_o),
  .cell_char_o      (cell_char_o),
  .cell_attribute_o (cell_attribute_o),
  .clear_screen_o   (clear_screen_o),
  .cursor_index_o   (cursor_index_o)
);

// ===== test/tb.sv =====
// Self-checking testbench for text_console_char_writer_top: a cursor tracker predicts each
// cell write and cursor update, while tasks drive characters and attribute writes.
// Depends on txcw_pkg and the RTL under hdl/.
module tb;

  localparam int unsigned GRID_COLS      = 80;
  localparam int unsigned GRID_ROWS      = 25;
  localparam int unsigned TAB_WIDTH      = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 106;

  localparam int MODE_MIXED = 0;
  localparam int MODE_TEXT  = 1;
  localparam int MODE_MOVES = 2;

  class cursor_tracker;
    int unsigned column;
    int unsigned row;
    logic [txcw_pkg::ATTR_W-1:0] attribute;
    txcw_pkg::result_t pending_updates[$];
    int mismatches;

    function new();
      column = 0;
      row = 0;
      attribute = txcw_pkg::ATTR_RESET;
      mismatches = 0;
    endfunction

    function logic [txcw_pkg::IDX_W-1:0] cell_number(int unsigned col, int unsigned r);
      int unsigned full;
      full = r * GRID_COLS + col;
      return full[txcw_pkg::IDX_W-1:0];
    endfunction

    // Moves to the start of the next row and reports whether the screen wraps.
    function bit next_row();
      column = 0;
      row++;
      if (row >= GRID_ROWS) begin
        row = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_char(logic [txcw_pkg::CHAR_W-1:0] code);
      txcw_pkg::result_t upd;
      int unsigned stop;
      upd = '0;
      case (code)
        txcw_pkg::CODE_NEWLINE: begin
          upd.clear_screen = next_row();
        end
        txcw_pkg::CODE_TAB: begin
          stop = column + TAB_WIDTH - (column % TAB_WIDTH);
          if (stop >= GRID_COLS) upd.clear_screen = next_row();
          else column = stop;
        end
        txcw_pkg::CODE_RETURN: begin
          column = 0;
        end
        default: begin
          upd.cell_write = 1'b1;
          upd.cell_index = cell_number(column, row);
          upd.cell_char = code;
          upd.cell_attribute = attribute;
          column++;
          if (column >= GRID_COLS) upd.clear_screen = next_row();
        end
      endcase
      upd.cursor_index = cell_number(column, row);
      pending_updates.push_back(upd);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_update(txcw_pkg::result_t got);
      txcw_pkg::result_t exp;
      if (pending_updates.size() == 0) begin
        report("result transaction with nothing pending");
        return;
      end
      exp = pending_updates.pop_front();
      if (got.cell_write !== exp.cell_write)
        report($sformatf("cell_write %b, predicted %b", got.cell_write, exp.cell_write));
      if (got.cell_index !== exp.cell_index)
        report($sformatf("cell_index %0d, predicted %0d", got.cell_index, exp.cell_index));
      if (got.cell_char !== exp.cell_char)
        report($sformatf("cell_char %h, predicted %h", got.cell_char, exp.cell_char));
      if (got.cell_attribute !== exp.cell_attribute)
        report($sformatf("cell_attribute %h, predicted %h",
                         got.cell_attribute, exp.cell_attribute));
      if (got.clear_screen !== exp.clear_screen)
        report($sformatf("clear_screen %b, predicted %b", got.clear_screen, exp.clear_screen));
      if (got.cursor_index !== exp.cursor_index)
        report($sformatf("cursor_index %0d, predicted %0d",
                         got.cursor_index, exp.cursor_index));
    endtask
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [txcw_pkg::CHAR_W-1:0] char_code_i;
  logic                        cfg_attribute_we_i;
  logic [txcw_pkg::ATTR_W-1:0] cfg_attribute_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        cell_write_o;
  logic [txcw_pkg::IDX_W-1:0]  cell_index_o;
  logic [txcw_pkg::CHAR_W-1:0] cell_char_o;
  logic [txcw_pkg::ATTR_W-1:0] cell_attribute_o;
  logic                        clear_screen_o;
  logic [txcw_pkg::IDX_W-1:0]  cursor_index_o;

  cursor_tracker     tracker;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       quiet_cycles;
  bit                progress;
  txcw_pkg::result_t seen;

  text_console_char_writer_top #(
    .COLUMNS (GRID_COLS),
    .ROWS    (GRID_ROWS),
    .TAB_STOP(TAB_WIDTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .char_code_i       (char_code_i),
    .cfg_attribute_we_i(cfg_attribute_we_i),
    .cfg_attribute_i   (cfg_attribute_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_write_o      (cell_write_o),
    .cell_index_o      (cell_index_o),
    .cell_char_o       (cell_char_o),
    .cell_attribute_o  (cell_attribute_o),
    .clear_screen_o    (clear_screen_o),
    .cursor_index_o    (cursor_index_o)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    cfg_attribute_we_i = 1'b0;
    cfg_attribute_i = '0;
    out_stall_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    tracker = new();
  end

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        tracker.take_char(char_code_i);
        progress = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        seen.cell_write = cell_write_o;
        seen.cell_index = cell_index_o;
        seen.cell_char = cell_char_o;
        seen.cell_attribute = cell_attribute_o;
        seen.clear_screen = clear_screen_o;
        seen.cursor_index = cursor_index_o;
        tracker.compare_update(seen);
        progress = 1'b1;
      end
      if (progress) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Entered and left just after a falling edge; valid stays high between back-to-back chars.
  task send_char(logic [txcw_pkg::CHAR_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      char_code_i <= txcw_pkg::CHAR_W'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_updates.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_attribute(logic [txcw_pkg::ATTR_W-1:0] value);
    cfg_attribute_we_i <= 1'b1;
    cfg_attribute_i <= value;
    @(negedge clk_i);
    cfg_attribute_we_i <= 1'b0;
    tracker.attribute = value;
    @(negedge clk_i);
  endtask

  function logic [txcw_pkg::CHAR_W-1:0] pick_code(int mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_TEXT: begin
        if (roll < 3) return txcw_pkg::CODE_RETURN;
        if (roll < 5) return txcw_pkg::CODE_NEWLINE;
      end
      MODE_MOVES: begin
        if (roll < 45) return txcw_pkg::CODE_TAB;
        if (roll < 85) return txcw_pkg::CODE_NEWLINE;
        if (roll < 90) return txcw_pkg::CODE_RETURN;
      end
      MODE_MIXED: begin
        if (roll < 25) return txcw_pkg::CODE_NEWLINE;
        if (roll < 35) return txcw_pkg::CODE_TAB;
        if (roll < 40) return txcw_pkg::CODE_RETURN;
      end
      default: begin
      end
    endcase
    return txcw_pkg::CHAR_W'($urandom);
  endfunction

  task run_phase(int unsigned items, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned sent;
    int unsigned burst;
    int mode;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(2);
      burst = (mode == MODE_TEXT) ? $urandom_range(100, 40) : $urandom_range(40, 8);
      repeat (burst) begin
        if (sent < items) begin
          send_char(pick_code(mode));
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(txcw_pkg::CODE_TAB);
    send_char(txcw_pkg::CODE_RETURN);
    send_char(txcw_pkg::CODE_NEWLINE);
    repeat (20) send_char(txcw_pkg::CODE_TAB);
    drain();

    write_attribute(8'h00);
    run_phase(PHASE_ITEMS, 0, 0);
    write_attribute(8'hFF);
    run_phase(PHASE_ITEMS, 77, 0);
    write_attribute(txcw_pkg::ATTR_W'($urandom));
    run_phase(PHASE_ITEMS, 0, 77);
    write_attribute(txcw_pkg::ATTR_W'($urandom));
    run_phase(PHASE_ITEMS, 27, 27);

    if (tracker.pending_updates.size() != 0)
      tracker.report($sformatf("%0d predicted results never arrived",
                               tracker.pending_updates.size()));
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
